### sv/bap_pkg.sv
// Shared types and constants of the block-average pixelation block.
// Depends on nothing; bap_front, bap_accum, bap_div and the top level refer to it by scoped names.
package bap_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int CHAN_W    = 8;
  localparam int SIZE_W    = 13;
  localparam int BSIZE_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_POS_W = 12;

  // Defaults for the top-level parameters.
  localparam int LINE_PIXELS_DEFAULT = 4096;
  localparam int BLOCK_EDGE_DEFAULT  = 64;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Register values after reset.
  localparam logic [SIZE_W-1:0]  WIDTH_AT_RESET  = 13'd600;
  localparam logic [SIZE_W-1:0]  HEIGHT_AT_RESET = 13'd800;
  localparam logic [BSIZE_W-1:0] BLOCK_AT_RESET  = 7'd30;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_SIZE   = 2'd2
  } cfg_index_t;

  // States of the averaging divider.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

endpackage

### sv/bap_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bap_fifo.sv
// Small register queue that decouples the pixel front end from the accumulator.
// Depends on nothing; DEPTH must be a power of two of at least two.
module bap_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### sv/bap_front.sv
// Front end: holds the size registers, tracks the raster position of each pixel
// and classifies it (block column, first pixel of block, block complete). Uses bap_pkg.
module bap_front #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_BLOCK_EDGE  = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bap_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  logic [3*bap_pkg::CHAN_W-1:0]    pix_rgb,
  output logic                            q_push,
  input  logic                            q_full,
  output logic [27 + 2*((MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1)
                + 2*(((MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1) + 1) - 1:0] q_data
);

  localparam int X_W   = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int OFS_W = (MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1;
  localparam int CNT_W = 2 * (OFS_W + 1);

  logic [bap_pkg::SIZE_W-1:0]  image_width;
  logic [bap_pkg::SIZE_W-1:0]  image_height;
  logic [bap_pkg::BSIZE_W-1:0] block_size;

  logic [X_W-1:0]   pixel_x;
  logic [X_W-1:0]   pixel_y;
  logic [OFS_W-1:0] offset_x;
  logic [OFS_W-1:0] offset_y;
  logic [X_W-1:0]   block_col;
  logic [X_W-1:0]   block_row;

  logic [X_W:0]     width_eff;
  logic [X_W:0]     height_eff;
  logic [OFS_W:0]   bsize_eff;
  logic             line_end;
  logic             frame_end;
  logic             blk_right;
  logic             blk_bottom;
  logic             first_pix;
  logic             emit;
  logic [CNT_W-1:0] pix_count;
  logic             accept;

  // Zero sizes act as one, oversize values saturate at the build limits.
  always_comb begin
    if (image_width == '0) begin
      width_eff = (X_W + 1)'(1);
    end else if (32'(image_width) > 32'(MAX_LINE_PIXELS)) begin
      width_eff = (X_W + 1)'(MAX_LINE_PIXELS);
    end else begin
      width_eff = (X_W + 1)'(image_width);
    end
    if (image_height == '0) begin
      height_eff = (X_W + 1)'(1);
    end else if (32'(image_height) > 32'(MAX_LINE_PIXELS)) begin
      height_eff = (X_W + 1)'(MAX_LINE_PIXELS);
    end else begin
      height_eff = (X_W + 1)'(image_height);
    end
    if (block_size == '0) begin
      bsize_eff = (OFS_W + 1)'(1);
    end else if (32'(block_size) > 32'(MAX_BLOCK_EDGE)) begin
      bsize_eff = (OFS_W + 1)'(MAX_BLOCK_EDGE);
    end else begin
      bsize_eff = (OFS_W + 1)'(block_size);
    end
  end

  assign line_end   = ({1'b0, pixel_x} + 1'b1) >= width_eff;
  assign frame_end  = ({1'b0, pixel_y} + 1'b1) >= height_eff;
  assign blk_right  = line_end || (({1'b0, offset_x} + 1'b1) >= bsize_eff);
  assign blk_bottom = frame_end || (({1'b0, offset_y} + 1'b1) >= bsize_eff);
  assign first_pix  = (offset_x == '0) && (offset_y == '0);
  assign emit       = blk_right && blk_bottom;
  assign pix_count  = CNT_W'(({1'b0, offset_x} + 1'b1) * ({1'b0, offset_y} + 1'b1));

  assign pix_ready = !q_full;
  assign accept    = pix_valid && !q_full;
  assign q_push    = accept;
  assign q_data    = {line_end && frame_end, block_row, pix_count, emit, first_pix,
                      block_col, pix_rgb};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bap_pkg::WIDTH_AT_RESET;
      image_height <= bap_pkg::HEIGHT_AT_RESET;
      block_size   <= bap_pkg::BLOCK_AT_RESET;
      pixel_x      <= '0;
      pixel_y      <= '0;
      offset_x     <= '0;
      offset_y     <= '0;
      block_col    <= '0;
      block_row    <= '0;
    end else if (cfg_we) begin
      unique case (bap_pkg::cfg_index_t'(cfg_index))
        bap_pkg::CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data;
        end
        bap_pkg::CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
        end
        bap_pkg::CFG_BLOCK_SIZE: begin
          block_size <= cfg_data[bap_pkg::BSIZE_W-1:0];
        end
        default: begin
        end
      endcase
      // Any write to a defined register restarts the frame.
      if (cfg_index == bap_pkg::CFG_IMAGE_WIDTH || cfg_index == bap_pkg::CFG_IMAGE_HEIGHT ||
          cfg_index == bap_pkg::CFG_BLOCK_SIZE) begin
        pixel_x   <= '0;
        pixel_y   <= '0;
        offset_x  <= '0;
        offset_y  <= '0;
        block_col <= '0;
        block_row <= '0;
      end
    end else if (accept) begin
      if (line_end) begin
        pixel_x   <= '0;
        offset_x  <= '0;
        block_col <= '0;
        if (frame_end) begin
          pixel_y   <= '0;
          offset_y  <= '0;
          block_row <= '0;
        end else begin
          pixel_y <= pixel_y + 1'b1;
          if (blk_bottom) begin
            offset_y  <= '0;
            block_row <= block_row + 1'b1;
          end else begin
            offset_y <= offset_y + 1'b1;
          end
        end
      end else begin
        pixel_x <= pixel_x + 1'b1;
        if (blk_right) begin
          offset_x  <= '0;
          block_col <= block_col + 1'b1;
        end else begin
          offset_x <= offset_x + 1'b1;
        end
      end
    end
  end

endmodule

### sv/bap_accum.sv
// Back end: read-modify-write of the per-block-column channel sums and hand-off
// of completed blocks to the divider. Uses bap_pkg and bap_ram.
module bap_accum #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_BLOCK_EDGE  = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  output logic q_pop,
  input  logic [27 + 2*((MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1)
                + 2*(((MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1) + 1) - 1:0] q_data,
  input  logic div_busy,
  output logic job_valid,
  output logic [3*(bap_pkg::CHAN_W + 2*((MAX_BLOCK_EDGE > 1) ?
                $clog2(MAX_BLOCK_EDGE) : 1))-1:0] job_sums,
  output logic [2*(((MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1) + 1)-1:0] job_count,
  output logic [((MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1)-1:0] job_col,
  output logic [((MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1)-1:0] job_row,
  output logic job_last
);

  localparam int X_W     = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int OFS_W   = (MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1;
  localparam int CNT_W   = 2 * (OFS_W + 1);
  localparam int SUM_W   = bap_pkg::CHAN_W + 2 * OFS_W;
  localparam int ENTRY_W = 27 + 2 * X_W + CNT_W;
  localparam int CH_W    = bap_pkg::CHAN_W;

  // Stage A issues the memory read; stage B adds and writes back.
  logic               a_valid;
  logic [ENTRY_W-1:0] a_entry;
  logic               b_valid;
  logic [ENTRY_W-1:0] b_entry;
  logic               a_go;
  logic               a_emit;

  logic [X_W-1:0]     a_col;
  logic [X_W-1:0]     b_col;
  logic               b_first;
  logic               b_emit;

  logic [3*SUM_W-1:0] ram_rdata;
  logic [3*SUM_W-1:0] old_sums;
  logic [3*SUM_W-1:0] new_sums;

  // Last value written, forwarded when the read raced that write.
  logic               fwd_valid;
  logic [X_W-1:0]     fwd_col;
  logic [3*SUM_W-1:0] fwd_data;

  assign a_col   = a_entry[3*CH_W +: X_W];
  assign a_emit  = a_entry[3*CH_W + X_W + 1];
  assign b_col   = b_entry[3*CH_W +: X_W];
  assign b_first = b_entry[3*CH_W + X_W];
  assign b_emit  = b_entry[3*CH_W + X_W + 1];

  // A block that completes may only move on when the divider will be free.
  assign a_go  = a_valid && (!a_emit || (!div_busy && !(b_valid && b_emit)));
  assign q_pop = q_not_empty && (!a_valid || a_go);

  assign old_sums = (fwd_valid && (fwd_col == b_col)) ? fwd_data : ram_rdata;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (b_first) begin
        new_sums[c*SUM_W +: SUM_W] = SUM_W'(b_entry[c*CH_W +: CH_W]);
      end else begin
        new_sums[c*SUM_W +: SUM_W] = old_sums[c*SUM_W +: SUM_W]
                                     + SUM_W'(b_entry[c*CH_W +: CH_W]);
      end
    end
  end

  bap_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_LINE_PIXELS)
  ) u_sums (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_col),
    .wdata (new_sums),
    .raddr (a_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_entry <= q_data;
    end
    if (a_go) begin
      b_entry <= a_entry;
    end
    if (b_valid) begin
      fwd_col  <= b_col;
      fwd_data <= new_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        a_valid <= 1'b1;
      end else if (a_go) begin
        a_valid <= 1'b0;
      end
      b_valid <= a_go;
      if (b_valid) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  assign job_valid = b_valid && b_emit;
  assign job_sums  = new_sums;
  assign job_count = b_entry[3*CH_W + X_W + 2 +: CNT_W];
  assign job_col   = b_col;
  assign job_row   = b_entry[3*CH_W + X_W + 2 + CNT_W +: X_W];
  assign job_last  = b_entry[3*CH_W + 2*X_W + 2 + CNT_W];

endmodule

### sv/bap_div.sv
// Shared averaging divider: one quotient bit per cycle for all three channels,
// followed by the output register of the result stream. Uses bap_pkg.
module bap_div #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_BLOCK_EDGE  = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  logic [3*(bap_pkg::CHAN_W + 2*((MAX_BLOCK_EDGE > 1) ?
                $clog2(MAX_BLOCK_EDGE) : 1))-1:0] job_sums,
  input  logic [2*(((MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1) + 1)-1:0] job_count,
  input  logic [((MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1)-1:0] job_col,
  input  logic [((MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1)-1:0] job_row,
  input  logic job_last,
  output logic busy,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [3*bap_pkg::CHAN_W + 2*bap_pkg::OUT_POS_W-1:0] m_tdata,
  output logic m_tlast
);

  localparam int X_W   = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int OFS_W = (MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1;
  localparam int CNT_W = 2 * (OFS_W + 1);
  localparam int SUM_W = bap_pkg::CHAN_W + 2 * OFS_W;
  localparam int STP_W = $clog2(SUM_W + 1);
  localparam int CH_W  = bap_pkg::CHAN_W;
  localparam int POS_W = bap_pkg::OUT_POS_W;

  bap_pkg::div_state_t state;
  bap_pkg::div_state_t state_next;

  logic [SUM_W-1:0] dividend [3];
  logic [CNT_W-1:0] remainder [3];
  logic [CH_W-1:0]  quotient [3];
  logic [SUM_W-1:0] dividend_next [3];
  logic [CNT_W-1:0] remainder_next [3];
  logic [CH_W-1:0]  quotient_next [3];
  logic [CNT_W-1:0] divisor;
  logic [STP_W-1:0] step;
  logic [X_W-1:0]   col;
  logic [X_W-1:0]   row;
  logic             last;
  logic             load_out;

  // One restoring-division step per channel.
  always_comb begin
    logic [CNT_W:0] trial;
    for (int c = 0; c < 3; c++) begin
      trial = {remainder[c], dividend[c][SUM_W-1]};
      if (trial >= {1'b0, divisor}) begin
        remainder_next[c] = CNT_W'(trial - {1'b0, divisor});
        quotient_next[c]  = {quotient[c][CH_W-2:0], 1'b1};
      end else begin
        remainder_next[c] = CNT_W'(trial);
        quotient_next[c]  = {quotient[c][CH_W-2:0], 1'b0};
      end
      dividend_next[c] = dividend[c] << 1;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      bap_pkg::DIV_IDLE: begin
        if (job_valid) begin
          state_next = bap_pkg::DIV_RUN;
        end
      end
      bap_pkg::DIV_RUN: begin
        if (step == STP_W'(SUM_W - 1)) begin
          state_next = bap_pkg::DIV_HOLD;
        end
      end
      bap_pkg::DIV_HOLD: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = bap_pkg::DIV_IDLE;
        end
      end
      default: begin
        state_next = bap_pkg::DIV_IDLE;
      end
    endcase
  end

  assign busy = (state != bap_pkg::DIV_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bap_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bap_pkg::DIV_IDLE && job_valid) begin
      for (int c = 0; c < 3; c++) begin
        dividend[c]  <= job_sums[c*SUM_W +: SUM_W];
        remainder[c] <= '0;
        quotient[c]  <= '0;
      end
      divisor <= job_count;
      col     <= job_col;
      row     <= job_row;
      last    <= job_last;
      step    <= '0;
    end else if (state == bap_pkg::DIV_RUN) begin
      for (int c = 0; c < 3; c++) begin
        dividend[c]  <= dividend_next[c];
        remainder[c] <= remainder_next[c];
        quotient[c]  <= quotient_next[c];
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {POS_W'(row), POS_W'(col), quotient[2], quotient[1], quotient[0]};
      m_tlast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### sv/block_average_pixelate.sv
// Block-average pixelation: top level tying the front end, queue, accumulator
// and divider together. Uses bap_pkg, bap_front, bap_fifo, bap_accum and bap_div.
//
// RGB pixels enter in raster order, one per beat on the slave stream. The image is
// cut into square blocks of block_size pixels on a side; for each block the block
// emits one beat on the master stream with the truncated mean of each channel and
// the block's column and line index, and tlast marks the block that holds the last
// pixel of the frame. Blocks cut off at the right or bottom border are averaged over
// their in-bounds pixels only. Pixels are taken at one per cycle for as long as the
// divider keeps up: each completed block occupies the shared three-channel divider
// while it works out one quotient bit per cycle, one for each of the SUM_W bits of a
// sum (SUM_W being 8 plus twice the block offset width), and until the result stream
// register is free to load the result. While a block waits for the divider, pixels
// still queue up in the four-deep queue behind the front end; when blocks complete
// faster than the divider frees up, input is held off. The per-column sums live in
// one memory of MAX_LINE_PIXELS entries; the first pixel of every block overwrites
// its entry, so the memory needs no clearing after reset. Writing any size register
// restarts the frame at the top-left corner; write registers only while the block is
// idle.
module block_average_pixelate #(
  parameter int MAX_LINE_PIXELS = bap_pkg::LINE_PIXELS_DEFAULT,
  parameter int MAX_BLOCK_EDGE  = bap_pkg::BLOCK_EDGE_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port: index 0 image_width, 1 image_height, 2 block_size.
  input  logic                                  cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bap_pkg::SIZE_W-1:0]            cfg_data,
  // Pixel stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata fields from bit 0 up: red_in, green_in, blue_in.
  input  logic [3*bap_pkg::CHAN_W-1:0]          s_tdata,
  // Block result stream; m_tlast is frame_done.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata fields from bit 0 up: avg_red, avg_green, avg_blue, block_column, block_line.
  output logic [3*bap_pkg::CHAN_W + 2*bap_pkg::OUT_POS_W-1:0] m_tdata,
  output logic                                  m_tlast
);

  localparam int X_W     = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int OFS_W   = (MAX_BLOCK_EDGE > 1) ? $clog2(MAX_BLOCK_EDGE) : 1;
  localparam int CNT_W   = 2 * (OFS_W + 1);
  localparam int SUM_W   = bap_pkg::CHAN_W + 2 * OFS_W;
  localparam int ENTRY_W = 27 + 2 * X_W + CNT_W;

  // Front end to queue.
  logic               q_push;
  logic               q_full;
  logic [ENTRY_W-1:0] q_push_data;

  // Queue to accumulator.
  logic               q_pop;
  logic               q_not_empty;
  logic [ENTRY_W-1:0] q_pop_data;

  // Accumulator to divider: a completed block with its sums and pixel count.
  logic               job_valid;
  logic [3*SUM_W-1:0] job_sums;
  logic [CNT_W-1:0]   job_count;
  logic [X_W-1:0]     job_col;
  logic [X_W-1:0]     job_row;
  logic               job_last;
  logic               div_busy;

  // The front end tracks the raster position and marks block boundaries.
  bap_front #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .MAX_BLOCK_EDGE  (MAX_BLOCK_EDGE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pix_rgb   (s_tdata),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_data    (q_push_data)
  );

  // The queue lets the front keep taking pixels while the back waits on the divider.
  bap_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (bap_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // The accumulator updates the column sums and hands finished blocks on.
  bap_accum #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .MAX_BLOCK_EDGE  (MAX_BLOCK_EDGE)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .q_data      (q_pop_data),
    .div_busy    (div_busy),
    .job_valid   (job_valid),
    .job_sums    (job_sums),
    .job_count   (job_count),
    .job_col     (job_col),
    .job_row     (job_row),
    .job_last    (job_last)
  );

  // The divider produces the three means and drives the result stream register.
  bap_div #(
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
    .MAX_BLOCK_EDGE  (MAX_BLOCK_EDGE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_sums  (job_sums),
    .job_count (job_count),
    .job_col   (job_col),
    .job_row   (job_row),
    .job_last  (job_last),
    .busy      (div_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
